// ===== hw/rtl/pfvl_pkg.sv =====
`timescale 1ns / 1ps

package pfvl_pkg;

   localparam int SAMPLE_W  = 32;
   localparam int LEVEL_W   = 16;
   localparam int GAIN_W    = 17;
   localparam int FMT_W     = 3;
   localparam int FRAME_W   = 64;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = 5;

   localparam logic [FMT_W-1:0] FMT_PCM16 = 3'd0;
   localparam logic [FMT_W-1:0] FMT_PCM24 = 3'd1;
   localparam logic [FMT_W-1:0] FMT_PCM32 = 3'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_FORMAT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEREO        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN          = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_OFFSET = 2'd3;

   localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'h10000;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL  = 5'b00010,
      S_ACC  = 5'b00100,
      S_DIV  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic acc;
      logic close;
      logic step;
   } lane_ctrl_type;

   // left-justified sample of one channel, zero for non-pcm formats
   function automatic logic [SAMPLE_W-1:0] unpack_sample(
      input logic [FRAME_W-1:0] frame,
      input logic [FMT_W-1:0]   fmt,
      input logic               upper
   );
      logic [SAMPLE_W-1:0] res;
      case (fmt)
         FMT_PCM16: begin
            res = upper ? {frame[31:16], 16'h0000} : {frame[15:0], 16'h0000};
         end
         FMT_PCM24: begin
            res = upper ? {frame[47:24], 8'h00} : {frame[23:0], 8'h00};
         end
         FMT_PCM32: begin
            res = upper ? frame[63:32] : frame[31:0];
         end
         default: begin
            res = '0;
         end
      endcase
      return res;
   endfunction

endpackage

// ===== hw/rtl/pfvl_lane.sv =====
`timescale 1ns / 1ps

module pfvl_lane
   import pfvl_pkg::*;
#(
   parameter int CNT_W = 11
) (
   input  logic                clock,
   input  logic                reset,
   input  lane_ctrl_type       ctrl,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic [GAIN_W-1:0]   gain,
   input  logic [SAMPLE_W-1:0] offset,
   input  logic [CNT_W-1:0]    divisor,
   output logic [SAMPLE_W-1:0] scaled,
   output logic [LEVEL_W-1:0]  level
);

   logic signed [SAMPLE_W-1:0] s_ff;
   logic signed [49:0]         prod_ff;
   logic signed [49:0]         prod_in;
   logic signed [31:0]         sq_ff;
   logic signed [31:0]         sq_in;
   logic signed [31:0]         q_full;
   logic signed [15:0]         q;
   logic signed [49:0]         biased;
   logic [SAMPLE_W-1:0]        scaled_ff;
   logic [SAMPLE_W-1:0]        scaled_in;
   logic [31:0]                sum_ff;
   logic [31:0]                sum_in;
   logic [LEVEL_W-1:0]         energy;
   logic [31:0]                quo_ff;
   logic [CNT_W-1:0]           rem_ff;
   logic [CNT_W:0]             trial;
   logic [CNT_W:0]             diff;
   logic                       ge;

   // truncate toward zero on the divide by 65536
   assign q_full  = s_ff + (s_ff[31] ? 32'sh0000ffff : 32'sh00000000);
   assign q       = q_full[31:16];
   assign sq_in   = q * q;
   assign prod_in = s_ff * $signed({1'b0, gain});

   assign biased    = prod_ff + (prod_ff[49] ? 50'sd65535 : 50'sd0);
   assign scaled_in = biased[47:16] + offset;
   assign energy    = sq_ff[30:15];
   assign sum_in    = sum_ff + {16'h0000, energy};

   // restoring divider, one quotient bit per step
   assign trial = {rem_ff, quo_ff[31]};
   assign diff  = trial - {1'b0, divisor};
   assign ge    = trial >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         s_ff <= sample;
      end
      if (ctrl.mul) begin
         prod_ff <= prod_in;
         sq_ff   <= sq_in;
      end
      if (ctrl.acc) begin
         scaled_ff <= scaled_in;
         if (ctrl.close) begin
            quo_ff <= sum_in;
            rem_ff <= '0;
         end
      end else if (ctrl.step) begin
         quo_ff <= {quo_ff[30:0], ge};
         rem_ff <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (ctrl.acc) begin
         sum_ff <= ctrl.close ? 32'h0 : sum_in;
      end
   end

   assign scaled = scaled_ff;
   assign level  = quo_ff[LEVEL_W-1:0];

endmodule

// ===== hw/rtl/pcm_frame_volume_and_level_unit.sv =====
`timescale 1ns / 1ps
// channel  direction  tdata (low bit up)                                   tlast
// req      in         frame_low, frame_high                                last_in_buffer
// rsp      out        left_sample, right_sample, left_level, right_level   last
// csr      in         csr_index 0 format, 1 stereo, 2 gain, 3 output_offset
//
// one item at a time: an item that does not close a buffer goes through the mul, acc and out states
// an item that closes a buffer also runs the 32-step serial divider between acc and out
// a finished item sits in the output register while the next item is taken
// synchronous reset restores register defaults and clears energy sums and count

module pcm_frame_volume_and_level_unit
   import pfvl_pkg::*;
#(
   parameter int BUFFER_FRAMES = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [63:0]          req_tdata,   // frame_low, frame_high
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [95:0]          rsp_tdata,   // left_sample, right_sample, left_level, right_level
   output logic                 rsp_tlast,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(BUFFER_FRAMES + 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BUFFER_FRAMES);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   logic [FMT_W-1:0]     fmt_ff;
   logic                 stereo_ff;
   logic [GAIN_W-1:0]    gain_ff;
   logic [SAMPLE_W-1:0]  offset_ff;

   state_type            state_ff;
   state_type            state_in;
   logic [CNT_W-1:0]     cnt_ff;
   logic [CNT_W-1:0]     cnt_in;
   logic [CNT_W-1:0]     divisor_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic                 last_ff;
   logic                 close_ff;
   logic                 close_in;
   logic                 rsp_valid_ff;
   logic [95:0]          rsp_data_ff;
   logic                 rsp_last_ff;
   logic                 accept;
   logic                 out_free;
   logic                 out_load;

   logic [SAMPLE_W-1:0]  left_raw;
   logic [SAMPLE_W-1:0]  right_raw;
   logic [SAMPLE_W-1:0]  left_scaled;
   logic [SAMPLE_W-1:0]  right_scaled;
   logic [LEVEL_W-1:0]   left_level;
   logic [LEVEL_W-1:0]   right_level;
   lane_ctrl_type        ctrl;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign out_load   = (state_ff == S_OUT) && out_free;

   assign cnt_in   = cnt_ff + CNT_W'(1);
   assign close_in = last_ff || (cnt_in >= CNT_LIMIT);

   assign left_raw  = unpack_sample(req_tdata, fmt_ff, 1'b0);
   assign right_raw = unpack_sample(req_tdata, fmt_ff, stereo_ff);

   assign ctrl.load  = accept;
   assign ctrl.mul   = (state_ff == S_MUL);
   assign ctrl.acc   = (state_ff == S_ACC);
   assign ctrl.close = close_in;
   assign ctrl.step  = (state_ff == S_DIV);

   pfvl_lane #(.CNT_W(CNT_W)) u_lane_left (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .sample  (left_raw),
      .gain    (gain_ff),
      .offset  (offset_ff),
      .divisor (divisor_ff),
      .scaled  (left_scaled),
      .level   (left_level)
   );

   pfvl_lane #(.CNT_W(CNT_W)) u_lane_right (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .sample  (right_raw),
      .gain    (gain_ff),
      .offset  (offset_ff),
      .divisor (divisor_ff),
      .scaled  (right_scaled),
      .level   (right_level)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= FMT_PCM16;
         stereo_ff <= 1'b1;
         gain_ff   <= GAIN_UNITY;
         offset_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SAMPLE_FORMAT: fmt_ff    <= csr_wdata[FMT_W-1:0];
            CSR_STEREO:        stereo_ff <= csr_wdata[0];
            CSR_GAIN:          gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_OUTPUT_OFFSET: offset_ff <= csr_wdata;
            default:           fmt_ff    <= fmt_ff;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_MUL;
         S_MUL:   state_in = S_ACC;
         S_ACC:   state_in = close_in ? S_DIV : S_OUT;
         S_DIV:   if (div_cnt_ff == DIV_LAST) state_in = S_OUT;
         S_OUT:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         div_cnt_ff   <= '0;
         close_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_ACC) begin
            cnt_ff     <= close_in ? '0 : cnt_in;
            close_ff   <= close_in;
            div_cnt_ff <= '0;
         end else if (state_ff == S_DIV) begin
            div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         last_ff <= req_tlast;
      end
      if (state_ff == S_ACC) begin
         divisor_ff <= cnt_in;
      end
      if (out_load) begin
         rsp_data_ff <= {close_ff ? right_level : '0, close_ff ? left_level : '0,
                         right_scaled, left_scaled};
         rsp_last_ff <= close_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CNT_LIMIT)
      else $error("frame count reached buffer size without closing");

   a_div_close: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> close_ff)
      else $error("divider running for an item that does not close");

   a_open_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tdata[95:64] == 32'h0))
      else $error("level nonzero on an item that does not close");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_OUT))
      else $error("result shown outside output state");
`endif

endmodule
